/* src/slc_pkg.sv */
package slc_pkg;

    // number format and table size
    localparam int FRAC_BITS       = 12;
    localparam int ACT_TABLE_DEPTH = 256;

    // field and datapath widths
    localparam int DATA_W     = 16;
    localparam int HID_W      = 14;
    localparam int COEFF_W    = 48;
    localparam int CFG_ADDR_W = 3;
    localparam int ACT_W      = FRAC_BITS + 1;
    localparam int TANH_W     = FRAC_BITS + 2;
    localparam int IDX_W      = $clog2(ACT_TABLE_DEPTH);
    localparam int POS_W      = DATA_W + IDX_W;
    localparam int MUL_W      = 17;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int STEP_W     = 5;

    localparam logic [STEP_W-1:0] STEP_LAST = 5'd20;

    // fixed-point constants
    localparam logic [ACT_W-1:0]  ONE           = ACT_W'(64'(1) << FRAC_BITS);
    localparam logic [DATA_W-1:0] HALF          = DATA_W'(64'(1) << (FRAC_BITS - 1));
    localparam logic [COEFF_W-1:0] COEFF_RESET  = {HALF, HALF, {DATA_W{1'b0}}};
    localparam logic signed [DATA_W-1:0] THRESH_RESET = HALF;
    localparam int HID_MAX = (1 << (HID_W - 1)) - 1;
    localparam int HID_MIN = -(1 << (HID_W - 1));
    localparam longint Q30 = longint'(1) << 30;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_IN_GATE     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FORGET_GATE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_GATE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CANDIDATE   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD   = 3'd4;

    typedef enum logic [1:0] {
        GATE_IN,
        GATE_FORGET,
        GATE_OUT,
        GATE_CAND
    } gate_t;

    typedef enum logic [2:0] {
        MUL_WI_X,
        MUL_WH_H,
        MUL_DIFF_FR,
        MUL_F_C,
        MUL_I_G,
        MUL_O_T
    } mul_sel_t;

    typedef enum logic {
        SUM_PRE,
        SUM_CELL
    } sum_dst_t;

    typedef enum logic [2:0] {
        FIN_IG,
        FIN_FG,
        FIN_OG,
        FIN_CG,
        FIN_TC
    } fin_dst_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } ctrl_state_t;

    // datapath commands for one sequence step
    typedef struct packed {
        logic     load_x;
        logic     mul_en;
        mul_sel_t mul_sel;
        gate_t    mul_gate;
        logic     acc_en;
        logic     sum_en;
        sum_dst_t sum_dst;
        gate_t    sum_gate;
        logic     lk_en;
        logic     lk_cell;
        logic     lk_dbl;
        logic     fin_en;
        fin_dst_t fin_dst;
        logic     hid_en;
    } slc_cmd_t;

    typedef logic [ACT_TABLE_DEPTH:0][ACT_W-1:0] act_tab_t;

    // saturate a wide signed value to 16 bits
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > ACC_W'(32767))
            r = 16'sh7fff;
        else if (v < ACC_W'(-32768))
            r = 16'sh8000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // shift-subtract division, evaluated only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-u) in Q30, series on a halved argument then repeated squaring
    function automatic longint exp_neg_q30(input logic [63:0] u);
        logic [63:0] t;
        logic [63:0] term;
        longint      sum;
        int          s;
        s = 0;
        for (int j = 0; j < 64; j++)
        begin
            if ((u >> s) > (64'(1) << 29))
                s = s + 1;
        end
        t    = u >> s;
        term = 64'(Q30);
        sum  = Q30;
        for (int n = 1; n <= 12; n++)
        begin
            term = udiv64(term * t, 64'(n) << 30);
            if ((n % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > Q30)
            sum = Q30;
        for (int n = 0; n < s; n++)
            sum = (sum * sum + (longint'(1) << 29)) >>> 30;
        return sum;
    endfunction

    // sigmoid samples over the whole 16-bit code range
    function automatic act_tab_t build_act_tab();
        act_tab_t    tab;
        logic [63:0] pos;
        logic [63:0] u;
        logic [63:0] q;
        longint      x;
        longint      den;
        for (int k = 0; k <= ACT_TABLE_DEPTH; k++)
        begin
            pos = udiv64(64'(k) << (46 - FRAC_BITS), 64'(ACT_TABLE_DEPTH));
            x   = longint'(pos) - (longint'(1) << (45 - FRAC_BITS));
            u   = (x < 0) ? 64'(-x) : 64'(x);
            den = Q30 + exp_neg_q30(u);
            q   = udiv64((64'(ONE) << 30) + 64'(den >>> 1), 64'(den));
            if (x < 0)
                tab[k] = ACT_W'(64'(ONE) - q);
            else
                tab[k] = ACT_W'(q);
        end
        return tab;
    endfunction

    localparam act_tab_t ACT_TAB = build_act_tab();

endpackage

/* src/scalar_lstm_cell_core.sv */
// channel   | signals                         | contents
// ----------+---------------------------------+------------------------------------------
// input     | s_tvalid s_tready s_tdata[15:0] | sample_in
// output    | m_tvalid m_tready m_tdata[15:0] | hidden_out in [13:0], zeros above
//           | m_tuser[0]                      | fired
// config    | cfg_we cfg_addr[2:0]            | cfg_wdata[47:0], register picked by index
//
// One request runs through an accept cycle and then a 21-step sequence that
// issues the four gates, the cell update and the output product through a
// single 17x17 multiplier and one activation table. New requests wait for the sequence to end.
// The result sits in an output register; a stalled output only holds the last
// sequence step while the output register is still full.
// Reset loads the coefficient and threshold defaults and clears cell and hidden state.
module scalar_lstm_cell_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [13:0] hidden_out, [15:14] zero
    output logic [0:0]  m_tuser,   // [0] fired
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [47:0] cfg_wdata
);
    import slc_pkg::*;

    slc_cmd_t                 cmd;
    logic signed [HID_W-1:0]  hidden_out;
    logic                     fired;

    // sequencer
    slc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // arithmetic and state
    slc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .sample_in  ($signed(s_tdata)),
        .cmd        (cmd),
        .hidden_out (hidden_out),
        .fired      (fired)
    );

    // output packing
    assign m_tdata = {2'b00, hidden_out};
    assign m_tuser = fired;

    // an accepted request keeps the block busy for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while sequence running");

    // a new result appears only after the sequencer loaded the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.hid_en))
        else $error("output valid without a result load");

    // the hidden value stays within plus or minus one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[13:0]) <= $signed(HID_W'(ONE)) || ONE > HID_MAX)
            && ($signed(m_tdata[13:0]) >= -$signed(HID_W'(ONE)) || ONE > HID_MAX))
        else $error("hidden value out of range");

endmodule

/* src/slc_ctrl.sv */
module slc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output slc_pkg::slc_cmd_t cmd
);
    import slc_pkg::*;

    ctrl_state_t        state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;

    // fixed schedule on the shared multiplier, later stages overlap earlier gates
    function automatic slc_cmd_t sched(input logic [STEP_W-1:0] step);
        slc_cmd_t c;
        c = '0;
        case (step)
            0:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_WI_X; c.mul_gate = GATE_IN;
            end
            1:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_WH_H; c.mul_gate = GATE_IN;
                c.acc_en = 1'b1;
            end
            2:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_WI_X; c.mul_gate = GATE_FORGET;
                c.sum_en = 1'b1; c.sum_dst = SUM_PRE; c.sum_gate = GATE_IN;
            end
            3:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_WH_H; c.mul_gate = GATE_FORGET;
                c.acc_en = 1'b1;
                c.lk_en  = 1'b1;
            end
            4:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_DIFF_FR;
                c.sum_en = 1'b1; c.sum_dst = SUM_PRE; c.sum_gate = GATE_FORGET;
            end
            5:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_WI_X; c.mul_gate = GATE_OUT;
                c.fin_en = 1'b1; c.fin_dst = FIN_IG;
                c.lk_en  = 1'b1;
            end
            6:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_DIFF_FR;
                c.acc_en = 1'b1;
            end
            7:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_WH_H; c.mul_gate = GATE_OUT;
                c.fin_en = 1'b1; c.fin_dst = FIN_FG;
            end
            8:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_WI_X; c.mul_gate = GATE_CAND;
                c.sum_en = 1'b1; c.sum_dst = SUM_PRE; c.sum_gate = GATE_OUT;
            end
            9:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_WH_H; c.mul_gate = GATE_CAND;
                c.acc_en = 1'b1;
                c.lk_en  = 1'b1;
            end
            10:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_DIFF_FR;
                c.sum_en = 1'b1; c.sum_dst = SUM_PRE; c.sum_gate = GATE_CAND;
            end
            11:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_F_C;
                c.fin_en = 1'b1; c.fin_dst = FIN_OG;
                c.lk_en  = 1'b1; c.lk_dbl = 1'b1;
            end
            12:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_DIFF_FR;
                c.acc_en = 1'b1;
            end
            13:
            begin
                c.fin_en = 1'b1; c.fin_dst = FIN_CG;
            end
            14:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_I_G;
            end
            15:
            begin
                c.sum_en = 1'b1; c.sum_dst = SUM_CELL;
            end
            16:
            begin
                c.lk_en = 1'b1; c.lk_cell = 1'b1; c.lk_dbl = 1'b1;
            end
            17:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_DIFF_FR;
            end
            18:
            begin
                c.fin_en = 1'b1; c.fin_dst = FIN_TC;
            end
            19:
            begin
                c.mul_en = 1'b1; c.mul_sel = MUL_O_T;
            end
            default:
            begin
                c = '0;
            end
        endcase
        return c;
    endfunction

    // state, step and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_x = 1'b1;
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                cmd = sched(step_reg);
                if (step_reg == STEP_LAST)
                begin
                    // hold the result until the output register is free
                    if (!out_valid_reg || m_tready)
                    begin
                        cmd.hid_en = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output request flag
    always_comb
    begin
        if (cmd.hid_en)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

endmodule

/* src/slc_datapath.sv */
module slc_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [slc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [slc_pkg::COEFF_W-1:0]           cfg_wdata,
    input  logic signed [slc_pkg::DATA_W-1:0]     sample_in,
    input  slc_pkg::slc_cmd_t                     cmd,
    output logic signed [slc_pkg::HID_W-1:0]      hidden_out,
    output logic                                  fired
);
    import slc_pkg::*;

    localparam logic signed [ACC_W-1:0]  RND_F_ACC  = ACC_W'(64'(1) << (FRAC_BITS - 1));
    localparam logic signed [PROD_W-1:0] RND_F_PROD = PROD_W'(64'(1) << (FRAC_BITS - 1));
    localparam logic signed [PROD_W-1:0] RND_16     = PROD_W'(64'(1) << 15);

    // configuration
    logic [COEFF_W-1:0]        coef_in_reg, coef_fg_reg, coef_og_reg, coef_cg_reg;
    logic signed [DATA_W-1:0]  thr_reg;

    // state kept between requests
    logic signed [DATA_W-1:0]  cell_reg, hprev_reg;

    // working registers
    logic signed [DATA_W-1:0]  x_reg;
    logic signed [PROD_W-1:0]  prod_reg, acc_reg;
    logic signed [DATA_W-1:0]  pre_reg;
    logic [ACT_W-1:0]          lo_reg;
    logic signed [ACT_W:0]     diff_reg;
    logic [15:0]               fr_reg;
    logic [ACT_W-1:0]          ig_reg, fg_reg, og_reg;
    logic signed [TANH_W-1:0]  cg_reg, tc_reg;
    logic signed [HID_W-1:0]   hid_reg;
    logic                      fired_reg;

    // combinational signals
    logic [COEFF_W-1:0]        mul_coef, sum_coef;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [ACC_W-1:0]   sum_full, sum_rnd, sum_bias;
    logic signed [DATA_W-1:0]  sum_sat, sum_b;
    logic signed [DATA_W-1:0]  lk_src, lk_arg;
    logic [DATA_W-1:0]         lk_off;
    logic [POS_W-1:0]          lk_pos;
    logic [IDX_W-1:0]          lk_idx;
    logic [IDX_W:0]            lk_idx_hi;
    logic [ACT_W-1:0]          lk_lo, lk_hi;
    logic signed [PROD_W-1:0]  fin_rnd;
    logic [ACT_W:0]            fin_y;
    logic [TANH_W-1:0]         fin_tanh;
    logic signed [PROD_W-1:0]  h_rnd;
    logic signed [HID_W-1:0]   h_clamp;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_in_reg <= COEFF_RESET;
            coef_fg_reg <= COEFF_RESET;
            coef_og_reg <= COEFF_RESET;
            coef_cg_reg <= COEFF_RESET;
            thr_reg     <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_IN_GATE:     coef_in_reg <= cfg_wdata;
                REG_FORGET_GATE: coef_fg_reg <= cfg_wdata;
                REG_OUT_GATE:    coef_og_reg <= cfg_wdata;
                REG_CANDIDATE:   coef_cg_reg <= cfg_wdata;
                REG_THRESHOLD:   thr_reg     <= cfg_wdata[DATA_W-1:0];
                default:         ;
            endcase
        end
    end

    // coefficient selection for the multiplier and the bias adder
    always_comb
    begin
        case (cmd.mul_gate)
            GATE_IN:     mul_coef = coef_in_reg;
            GATE_FORGET: mul_coef = coef_fg_reg;
            GATE_OUT:    mul_coef = coef_og_reg;
            default:     mul_coef = coef_cg_reg;
        endcase
        case (cmd.sum_gate)
            GATE_IN:     sum_coef = coef_in_reg;
            GATE_FORGET: sum_coef = coef_fg_reg;
            GATE_OUT:    sum_coef = coef_og_reg;
            default:     sum_coef = coef_cg_reg;
        endcase
    end

    // shared multiplier operands
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_WI_X:
            begin
                mul_a = MUL_W'($signed(mul_coef[47:32]));
                mul_b = MUL_W'(x_reg);
            end
            MUL_WH_H:
            begin
                mul_a = MUL_W'($signed(mul_coef[31:16]));
                mul_b = MUL_W'(hprev_reg);
            end
            MUL_DIFF_FR:
            begin
                mul_a = MUL_W'(diff_reg);
                mul_b = $signed({1'b0, fr_reg});
            end
            MUL_F_C:
            begin
                mul_a = MUL_W'($signed({1'b0, fg_reg}));
                mul_b = MUL_W'(cell_reg);
            end
            MUL_I_G:
            begin
                mul_a = MUL_W'($signed({1'b0, ig_reg}));
                mul_b = MUL_W'(cg_reg);
            end
            MUL_O_T:
            begin
                mul_a = MUL_W'($signed({1'b0, og_reg}));
                mul_b = MUL_W'(tc_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sum of two products, rounded, biased (gate pre-activations only) and saturated
    always_comb
    begin
        sum_b    = $signed(sum_coef[15:0]);
        sum_full = ACC_W'(acc_reg) + ACC_W'(prod_reg);
        sum_rnd  = (sum_full + RND_F_ACC) >>> FRAC_BITS;
        if (cmd.sum_dst == SUM_PRE)
            sum_bias = sum_rnd + ACC_W'(sum_b);
        else
            sum_bias = sum_rnd;
        sum_sat = sat16(sum_bias);
    end

    // activation table lookup, argument doubled for tanh
    always_comb
    begin
        lk_src    = cmd.lk_cell ? cell_reg : pre_reg;
        lk_arg    = cmd.lk_dbl ? sat16(ACC_W'(lk_src) + ACC_W'(lk_src)) : lk_src;
        lk_off    = {~lk_arg[DATA_W-1], lk_arg[DATA_W-2:0]};
        lk_pos    = POS_W'(lk_off) * POS_W'(ACT_TABLE_DEPTH);
        lk_idx    = lk_pos[POS_W-1:16];
        lk_idx_hi = {1'b0, lk_idx} + 1'b1;
        lk_lo     = ACT_TAB[lk_idx];
        lk_hi     = ACT_TAB[lk_idx_hi];
    end

    // interpolation finish
    always_comb
    begin
        fin_rnd  = (prod_reg + RND_16) >>> 16;
        fin_y    = {1'b0, lo_reg} + fin_rnd[ACT_W:0];
        fin_tanh = {fin_y[ACT_W-1:0], 1'b0} - TANH_W'(ONE);
    end

    // hidden value, rounded and clamped to the output width
    always_comb
    begin
        h_rnd = (prod_reg + RND_F_PROD) >>> FRAC_BITS;
        if (h_rnd > PROD_W'(HID_MAX))
            h_clamp = HID_W'(HID_MAX);
        else if (h_rnd < PROD_W'(HID_MIN))
            h_clamp = HID_W'(HID_MIN);
        else
            h_clamp = h_rnd[HID_W-1:0];
    end

    // cell and hidden state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg  <= '0;
            hprev_reg <= '0;
        end
        else
        begin
            if (cmd.sum_en && cmd.sum_dst == SUM_CELL)
                cell_reg <= sum_sat;
            if (cmd.hid_en)
                hprev_reg <= DATA_W'(h_clamp);
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
            x_reg <= sample_in;
        if (cmd.mul_en)
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (cmd.acc_en)
            acc_reg <= prod_reg;
        if (cmd.sum_en && cmd.sum_dst == SUM_PRE)
            pre_reg <= sum_sat;
        if (cmd.lk_en)
        begin
            lo_reg   <= lk_lo;
            diff_reg <= $signed({1'b0, lk_hi}) - $signed({1'b0, lk_lo});
            fr_reg   <= lk_pos[15:0];
        end
        if (cmd.fin_en)
        begin
            case (cmd.fin_dst)
                FIN_IG:  ig_reg <= fin_y[ACT_W-1:0];
                FIN_FG:  fg_reg <= fin_y[ACT_W-1:0];
                FIN_OG:  og_reg <= fin_y[ACT_W-1:0];
                FIN_CG:  cg_reg <= fin_tanh;
                FIN_TC:  tc_reg <= fin_tanh;
                default: ;
            endcase
        end
        if (cmd.hid_en)
        begin
            hid_reg   <= h_clamp;
            fired_reg <= (DATA_W'(h_clamp) > thr_reg);
        end
    end

    assign hidden_out = hid_reg;
    assign fired      = fired_reg;

endmodule
